### sv/rgbenc_pkg.sv
// ----------------------------------------------------------------------------
// rgbenc_pkg
// Shared types, constants and the gamma table of the RGB LED bit encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbenc_pkg;

   // Field widths
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned PW_W    = 6;
   localparam int unsigned SLOT_W  = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 7;
   localparam int unsigned BITS_PER_PIXEL = 3 * CHAN_W;

   // Slot counts saturate here
   localparam logic [SLOT_W-1:0] MAX_SLOTS   = 7'd64;
   localparam logic [SLOT_W-1:0] PIXEL_SYMS  = 7'd24;
   localparam logic [SLOT_W-1:0] ONE_SLOT    = 7'd1;

   // Register reset values
   localparam logic [PW_W-1:0]   HIGH_COMPARE_RST = 6'd22;
   localparam logic [PW_W-1:0]   LOW_COMPARE_RST  = 6'd8;
   localparam logic [SLOT_W-1:0] LEAD_SLOTS_RST   = 7'd64;
   localparam logic [SLOT_W-1:0] TRAIL_SLOTS_RST  = 7'd64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_COMPARE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_COMPARE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_SLOTS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIL_SLOTS  = 2'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic load;    // load shifter with gamma-corrected pixel
      logic shift;   // advance shifter by one bit
      logic emit;    // write one symbol into the output register
      logic pixel;   // symbol is a data bit, not an idle slot
      logic last;    // final symbol of the request
      logic done;    // final slot of an end-frame run
      logic pwr;     // power enable reported with done
   } seq_ctrl_type;

   // Gamma table: floor(255*(i/255)^2.8 + 0.5)
   localparam logic [CHAN_W-1:0] GAMMA_ROM [0:255] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,
      8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,
      8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,
      8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
      8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,
      8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,  8'd17,  8'd17,  8'd18,  8'd18,
      8'd19,  8'd19,  8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,
      8'd24,  8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd37,  8'd38,
      8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
      8'd48,  8'd49,  8'd50,  8'd50,  8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,
      8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
      8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,  8'd79,  8'd81,
      8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,  8'd90,  8'd92,  8'd93,  8'd95,
      8'd96,  8'd98,  8'd99,  8'd101, 8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110,
      8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
      8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142, 8'd144, 8'd146,
      8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164, 8'd167,
      8'd169, 8'd171, 8'd173, 8'd175, 8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189,
      8'd191, 8'd193, 8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
      8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233, 8'd236, 8'd239,
      8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
   };

endpackage

### sv/rgb_led_gamma_bit_encoder_top.sv
// Turns start-frame, pixel and end-frame requests into a stream of timer
// compare counts, one symbol per clock while the output side takes them.
// A pixel request yields 24 symbols (gamma-corrected red, green, blue, MSB
// first), taking one bit of the symbol shifter per symbol; start frame yields
// min(lead_slots, 64) symbols, or none when that count is zero, end frame
// max(1, min(trail_slots, 64)) symbols, and an unused command none. A new
// request is taken in the cycle its predecessor's last symbol is written, so
// back-to-back requests leave no gap; stalls on the result side pause this.
// Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
// rgb_led_gamma_bit_encoder_top
// Top level: register file, sequencer, symbol shifter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_led_gamma_bit_encoder_top
   import rgbenc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [CHAN_W-1:0]      req_red,
   input  logic [CHAN_W-1:0]      req_green,
   input  logic [CHAN_W-1:0]      req_blue,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PW_W-1:0]        rsp_pulse_width,
   output logic                   rsp_run_last,
   output logic                   rsp_frame_done,
   output logic                   rsp_power_enable,
   // register write port
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [PW_W-1:0]    high_compare_ff;
   logic [PW_W-1:0]    low_compare_ff;
   logic [SLOT_W-1:0]  lead_slots_ff;
   logic [SLOT_W-1:0]  trail_slots_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PW_W-1:0]    pulse_width_ff, pulse_width_in;
   logic               run_last_ff;
   logic               frame_done_ff;
   logic               power_enable_ff;

   seq_ctrl_type       ctrl;
   logic               bit_out;
   logic               out_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_compare_ff <= HIGH_COMPARE_RST;
         low_compare_ff  <= LOW_COMPARE_RST;
         lead_slots_ff   <= LEAD_SLOTS_RST;
         trail_slots_ff  <= TRAIL_SLOTS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HIGH_COMPARE: high_compare_ff <= csr_write_data[PW_W-1:0];
            CSR_LOW_COMPARE:  low_compare_ff  <= csr_write_data[PW_W-1:0];
            CSR_LEAD_SLOTS:   lead_slots_ff   <= csr_write_data[SLOT_W-1:0];
            CSR_TRAIL_SLOTS:  trail_slots_ff  <= csr_write_data[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   rgbenc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .lead_slots  (lead_slots_ff),
      .trail_slots (trail_slots_ff),
      .out_free    (out_free),
      .req_ready   (req_ready),
      .ctrl        (ctrl)
   );

   rgbenc_shift u_shift (
      .clock   (clock),
      .ctrl    (ctrl),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .bit_out (bit_out)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.pixel) begin
         pulse_width_in = bit_out ? high_compare_ff : low_compare_ff;
      end else begin
         pulse_width_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         pulse_width_ff  <= pulse_width_in;
         run_last_ff     <= ctrl.last;
         frame_done_ff   <= ctrl.done;
         power_enable_ff <= ctrl.pwr;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pulse_width  = pulse_width_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_frame_done   = frame_done_ff;
   assign rsp_power_enable = power_enable_ff;

   // A pixel request keeps the block busy past the next cycle
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_PIXEL) |=> !req_ready)
      else $error("request taken during pixel run");

   // Frame done only on the last symbol of a run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_run_last)
      else $error("frame done without run last");

   // Power enable travels only with frame done
   a_pwr_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_power_enable) |-> rsp_frame_done)
      else $error("power enable outside frame done");

   // The final end-frame slot carries zero width
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_pulse_width == '0))
      else $error("nonzero width on trailing slot");

endmodule

### sv/rgbenc_shift.sv
// ----------------------------------------------------------------------------
// rgbenc_shift
// Symbol shifter: loads the gamma-corrected pixel, red then green then blue,
// and hands out one bit per symbol, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbenc_shift
   import rgbenc_pkg::*;
(
   input  logic                clock,
   input  seq_ctrl_type        ctrl,
   input  logic [CHAN_W-1:0]   red,
   input  logic [CHAN_W-1:0]   green,
   input  logic [CHAN_W-1:0]   blue,
   output logic                bit_out
);

   logic [BITS_PER_PIXEL-1:0] bits_ff;
   logic [BITS_PER_PIXEL-1:0] bits_in;

   // Load wins over shift; shift moves the next bit into the MSB
   always_comb begin
      bits_in = bits_ff;
      if (ctrl.load) begin
         bits_in = {GAMMA_ROM[red], GAMMA_ROM[green], GAMMA_ROM[blue]};
      end else if (ctrl.shift) begin
         bits_in = {bits_ff[BITS_PER_PIXEL-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

   assign bit_out = bits_ff[BITS_PER_PIXEL-1];

endmodule

### sv/rgbenc_seq.sv
// ----------------------------------------------------------------------------
// rgbenc_seq
// Request sequencer: slot counter, command register and the lit flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbenc_seq
   import rgbenc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic [SLOT_W-1:0]   lead_slots,
   input  logic [SLOT_W-1:0]   trail_slots,
   input  logic                out_free,
   output logic                req_ready,
   output seq_ctrl_type        ctrl
);

   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  remain_ff, remain_in;
   logic               any_lit_ff, any_lit_in;

   command_type        req_cmd;
   logic               accept;
   logic               emit;
   logic               final_sym;
   logic [SLOT_W-1:0]  lead_count;
   logic [SLOT_W-1:0]  trail_count;
   logic [SLOT_W-1:0]  start_count;
   state_type          start_state;

   assign req_cmd = command_type'(req_command);

   // Saturated slot counts; end frame always emits at least one slot
   always_comb begin
      lead_count  = (lead_slots > MAX_SLOTS) ? MAX_SLOTS : lead_slots;
      trail_count = (trail_slots > MAX_SLOTS) ? MAX_SLOTS : trail_slots;
      if (trail_count == '0) begin
         trail_count = ONE_SLOT;
      end
   end

   // Symbol count and state taken on by a new request
   always_comb begin
      start_count = '0;
      start_state = ST_IDLE;
      case (req_cmd)
         CMD_START: begin
            start_count = lead_count;
            start_state = (lead_count != '0) ? ST_RUN : ST_IDLE;
         end
         CMD_PIXEL: begin
            start_count = PIXEL_SYMS;
            start_state = ST_RUN;
         end
         CMD_END: begin
            start_count = trail_count;
            start_state = ST_RUN;
         end
         default: begin
            start_count = '0;
            start_state = ST_IDLE;
         end
      endcase
   end

   assign emit      = (state_ff == ST_RUN) && out_free;
   assign final_sym = emit && (remain_ff == ONE_SLOT);
   assign accept    = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = start_state;
            end
         end
         ST_RUN: begin
            if (final_sym) begin
               state_in = accept ? start_state : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: ready when idle, or as the final symbol goes out
   always_comb begin
      req_ready  = (state_ff == ST_IDLE) || final_sym;
      ctrl.load  = accept && (req_cmd == CMD_PIXEL);
      ctrl.shift = emit && (cmd_ff == CMD_PIXEL);
      ctrl.emit  = emit;
      ctrl.pixel = (cmd_ff == CMD_PIXEL);
      ctrl.last  = final_sym;
      ctrl.done  = final_sym && (cmd_ff == CMD_END);
      ctrl.pwr   = final_sym && (cmd_ff == CMD_END) && any_lit_ff;
   end

   // Counter, command and lit flag
   always_comb begin
      cmd_in     = cmd_ff;
      remain_in  = remain_ff;
      any_lit_in = any_lit_ff;
      if (emit) begin
         remain_in = remain_ff - ONE_SLOT;
      end
      if (accept) begin
         cmd_in    = req_cmd;
         remain_in = start_count;
         if (req_cmd == CMD_START) begin
            any_lit_in = 1'b0;
         end else if (req_cmd == CMD_PIXEL &&
                      (req_red != '0 || req_green != '0 || req_blue != '0)) begin
            any_lit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmd_ff     <= CMD_NONE;
         remain_ff  <= '0;
         any_lit_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmd_ff     <= cmd_in;
         remain_ff  <= remain_in;
         any_lit_ff <= any_lit_in;
      end
   end

endmodule
